// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed: property violated");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed: forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// ----- rtl/core/fdec_pkg.sv -----
package fdec_pkg;

  localparam int TAPS        = 255;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 18;
  localparam int DECIM_MAX   = 64;

  localparam int ADDR_W      = $clog2(TAPS);
  localparam int FACTOR_W    = 7;
  localparam int PHASE_W     = 6;
  localparam int PROD_W      = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W       = PROD_W + $clog2(TAPS);
  localparam int SHIFT       = COEF_BITS - 2;
  localparam int RND_W       = ACC_W + 1;
  localparam int RES_W       = RND_W - SHIFT;

  // Stream layout of the request word.
  localparam int IN_TDATA_W  = 48;
  localparam int TIDX_LO     = SAMPLE_BITS;
  localparam int TVAL_LO     = SAMPLE_BITS + 8;

  // Request kinds carried in tuser.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_COEF   = 1'b1;

  // Register map.
  localparam logic REG_DECIM_FACTOR = 1'b0;
  localparam logic [FACTOR_W-1:0] DECIM_RESET = FACTOR_W'(1);

endpackage

// ----- rtl/core/fir_decimator_windowed_sinc.sv -----
// Channel   | Direction | Accepted when            | Payload
// ----------+-----------+--------------------------+------------------------------------------
// s_axis    | in        | s_axis_tvalid & tready   | tuser: cmd; tdata: sample, tap idx, tap val
// m_axis    | out       | m_axis_tvalid & tready   | tuser: saturated; tdata: sample_out
// apb       | in        | psel & penable & pwrite  | decim_factor at byte address 0
//
// A coefficient request, or a sample request that gives no result, leaves the block idle
// and ready for the next request. A sample request that gives a result holds off new requests
// until that result is loaded: the MAC loop reads one history entry and one tap per cycle
// from the two single-read-port memories, then drains the read, multiply and add registers.
// Reset (rst, synchronous) clears pointers, fill count, phase and the factor;
// the memories are not cleared. The output register holds a result while
// m_axis_tready is low; new requests are still taken then, and the MAC loop
// waits at its end until the output register is free.
module fir_decimator_windowed_sinc (
  input  logic                                clk,
  input  logic                                rst,
  // Request stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [fdec_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // sample_in[15:0], tap_index[23:16],
                                                             // tap_value[41:24], zero pad[47:42]
  input  logic                                s_axis_tuser,  // cmd[0]
  // Result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [fdec_pkg::SAMPLE_BITS-1:0]    m_axis_tdata,  // sample_out[15:0]
  output logic                                m_axis_tuser,  // saturated[0]
  // Register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MAC   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  localparam int AW = fdec_pkg::ADDR_W;
  localparam int FW = fdec_pkg::FACTOR_W;
  localparam int PW = fdec_pkg::PHASE_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(fdec_pkg::TAPS - 1);
  localparam logic [AW-1:0] FULL      = AW'(fdec_pkg::TAPS);

  logic [1:0]    state, state_next;
  logic [FW-1:0] decim_factor;
  logic [AW-1:0] write_pointer, wp_next;
  logic [AW-1:0] fill_count, fill_next;
  logic [PW-1:0] decim_phase, phase_next;

  // Request decode
  logic                                  in_acc;
  logic                                  in_cmd;
  logic signed [fdec_pkg::SAMPLE_BITS-1:0] in_sample;
  logic [AW-1:0]                         in_tap_index;
  logic signed [fdec_pkg::COEF_BITS-1:0] in_tap_value;
  logic                                  hist_we, tap_we, fire;

  // Decimation
  logic [FW-1:0] dec_eff, phase_base, phase_inc;

  // MAC loop
  logic [AW-1:0] tap_k, ring_idx;
  logic          rd_en, rd_vld, prod_vld;
  logic signed [fdec_pkg::SAMPLE_BITS-1:0] hist_mem [0:fdec_pkg::TAPS-1];
  logic signed [fdec_pkg::COEF_BITS-1:0]   tap_mem  [0:fdec_pkg::TAPS-1];
  logic signed [fdec_pkg::SAMPLE_BITS-1:0] hist_q;
  logic signed [fdec_pkg::COEF_BITS-1:0]   tap_q;
  logic signed [fdec_pkg::PROD_W-1:0]      prod;
  logic signed [fdec_pkg::ACC_W-1:0]       acc;

  // Rounding and clipping
  logic signed [fdec_pkg::RND_W-1:0] acc_rnd;
  logic [fdec_pkg::RES_W-1:0]        res;
  logic                              res_sat;
  logic [fdec_pkg::SAMPLE_BITS-1:0]  res_clip;
  logic                              out_free, out_load;

  assign in_acc       = s_axis_tvalid && s_axis_tready;
  assign in_cmd       = s_axis_tuser;
  assign in_sample    = s_axis_tdata[fdec_pkg::SAMPLE_BITS-1:0];
  assign in_tap_index = s_axis_tdata[fdec_pkg::TIDX_LO +: AW];
  assign in_tap_value = s_axis_tdata[fdec_pkg::TVAL_LO +: fdec_pkg::COEF_BITS];

  assign s_axis_tready = (state == ST_IDLE);

  // ---------------------------------------------------------------------------
  // Register port: no wait states. Write the factor only while no request is
  // in flight.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == fdec_pkg::REG_DECIM_FACTOR) begin
      prdata = {{(32 - FW){1'b0}}, decim_factor};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decim_factor <= fdec_pkg::DECIM_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == fdec_pkg::REG_DECIM_FACTOR) begin
      decim_factor <= pwdata[FW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Ring pointer, fill count and decimation phase, all advanced on a sample.
  // ---------------------------------------------------------------------------
  assign hist_we   = in_acc && (in_cmd == fdec_pkg::CMD_SAMPLE);
  assign tap_we    = in_acc && (in_cmd == fdec_pkg::CMD_COEF) && (in_tap_index < FULL);
  assign wp_next   = (write_pointer == LAST_ADDR) ? '0 : write_pointer + AW'(1);
  assign fill_next = (fill_count < FULL) ? fill_count + AW'(1) : fill_count;

  // Zero acts as one, anything beyond the maximum acts as the maximum.
  always_comb begin
    if (decim_factor == '0) begin
      dec_eff = FW'(1);
    end else if (decim_factor > FW'(fdec_pkg::DECIM_MAX)) begin
      dec_eff = FW'(fdec_pkg::DECIM_MAX);
    end else begin
      dec_eff = decim_factor;
    end
  end

  always_comb begin
    // A phase left at or above a newly lowered factor restarts at zero.
    phase_base = ({1'b0, decim_phase} >= dec_eff) ? '0 : {1'b0, decim_phase};
    phase_inc  = phase_base + FW'(1);
    fire       = 1'b0;
    phase_next = decim_phase;
    if (fill_next == FULL) begin
      if (phase_base != '0) begin
        phase_next = (phase_inc >= dec_eff) ? '0 : phase_inc[PW-1:0];
      end else begin
        fire       = 1'b1;
        phase_next = (dec_eff > FW'(1)) ? PW'(1) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      fill_count    <= '0;
      decim_phase   <= '0;
    end else if (hist_we) begin
      write_pointer <= wp_next;
      fill_count    <= fill_next;
      decim_phase   <= phase_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: idle -> MAC over all taps -> drain pipeline and hand off.
  // ---------------------------------------------------------------------------
  assign rd_en    = (state == ST_MAC);
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign out_load = (state == ST_DRAIN) && !rd_vld && !prod_vld && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (hist_we && fire) begin
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        if (tap_k == LAST_ADDR) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rd_vld   <= 1'b0;
      prod_vld <= 1'b0;
    end else begin
      state    <= state_next;
      rd_vld   <= rd_en;
      prod_vld <= rd_vld;
    end
  end

  // Tap index and ring index; the ring walk starts at the oldest sample,
  // which is the slot the next sample will overwrite.
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_k    <= '0;
      ring_idx <= '0;
    end else if (state == ST_IDLE) begin
      tap_k    <= '0;
      ring_idx <= wp_next;
    end else if (rd_en) begin
      tap_k    <= tap_k + AW'(1);
      ring_idx <= (ring_idx == LAST_ADDR) ? '0 : ring_idx + AW'(1);
    end
  end

  // History and tap memories: one write port, one registered read port each.
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[write_pointer] <= in_sample;
    end
    if (tap_we) begin
      tap_mem[in_tap_index] <= in_tap_value;
    end
    if (rd_en) begin
      hist_q <= hist_mem[ring_idx];
      tap_q  <= tap_mem[tap_k];
    end
  end

  // Multiply, then accumulate exactly.
  always_ff @(posedge clk) begin
    if (rd_vld) begin
      prod <= hist_q * tap_q;
    end
    if (state == ST_IDLE) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + {{(fdec_pkg::ACC_W - fdec_pkg::PROD_W){prod[fdec_pkg::PROD_W-1]}}, prod};
    end
  end

  // ---------------------------------------------------------------------------
  // Round half up to Q1.15 and clip.
  // ---------------------------------------------------------------------------
  always_comb begin
    acc_rnd = {acc[fdec_pkg::ACC_W-1], acc}
              + (fdec_pkg::RND_W'(1) <<< (fdec_pkg::SHIFT - 1));
    res     = acc_rnd[fdec_pkg::RND_W-1:fdec_pkg::SHIFT];
    // Fits when every bit above the result's sign bit equals that sign.
    res_sat = !((&res[fdec_pkg::RES_W-1:fdec_pkg::SAMPLE_BITS-1]) ||
                !(|res[fdec_pkg::RES_W-1:fdec_pkg::SAMPLE_BITS-1]));
    if (!res_sat) begin
      res_clip = res[fdec_pkg::SAMPLE_BITS-1:0];
    end else if (res[fdec_pkg::RES_W-1]) begin
      res_clip = {1'b1, {(fdec_pkg::SAMPLE_BITS - 1){1'b0}}};
    end else begin
      res_clip = {1'b0, {(fdec_pkg::SAMPLE_BITS - 1){1'b1}}};
    end
  end

  // Output register: hold until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= res_clip;
      m_axis_tuser <= res_sat;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `include "assert_macros.svh"

  `ASSERT_NEVER(a_fill_bound, clk, rst, fill_count > FULL)
  `ASSERT_NEVER(a_wp_bound, clk, rst, write_pointer > LAST_ADDR)
  `ASSERT_PROP(a_idle_pipe_empty, clk, rst, (state == ST_IDLE) |-> (!rd_vld && !prod_vld))
  `ASSERT_PROP(a_load_needs_room, clk, rst, out_load |-> out_free)

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Chance in a hundred that a side idles on a given cycle.
  localparam int IDLE_PCT = 24;
  // Cycles to hold off after the last result before touching the register:
  // one full MAC pass plus margin.
  localparam int SETTLE_CYCLES = fdec_pkg::TAPS + 20;
  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 18;
  localparam longint OUT_HI = (longint'(1) <<< (fdec_pkg::SAMPLE_BITS - 1)) - 1;
  localparam longint OUT_LO = -(longint'(1) <<< (fdec_pkg::SAMPLE_BITS - 1));

  typedef struct {
    logic                                    cmd;
    logic signed [fdec_pkg::SAMPLE_BITS-1:0] sample;
    logic [7:0]                              tidx;
    logic signed [fdec_pkg::COEF_BITS-1:0]   tval;
  } fir_req_t;

  typedef struct {
    logic signed [fdec_pkg::SAMPLE_BITS-1:0] value;
    logic                                    sat;
  } fir_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [fdec_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                             s_axis_tuser = fdec_pkg::CMD_SAMPLE;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [fdec_pkg::SAMPLE_BITS-1:0] m_axis_tdata;
  logic                             m_axis_tuser;
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [2:0]                       paddr = '0;
  logic [31:0]                      pwdata = '0;
  logic [31:0]                      prdata;
  logic                             pready;

  fir_decimator_windowed_sinc dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Requests waiting to be driven, and filtered outputs still to come back.
  fir_req_t req_queue[$];
  fir_out_t out_expected[$];
  fir_req_t held_req;
  fir_out_t out_head;
  logic     req_fire = 1'b0;
  bit       calm = 1'b0;
  int       err_count = 0;

  // Shadow of the filter state: history ring, tap table, pointers, factor.
  logic signed [fdec_pkg::SAMPLE_BITS-1:0] hist_ring [fdec_pkg::TAPS];
  logic signed [fdec_pkg::COEF_BITS-1:0]   coef_table [fdec_pkg::TAPS];
  int                                      wr_ptr = 0;
  int                                      held = 0;
  int                                      dphase = 0;
  logic [fdec_pkg::FACTOR_W-1:0]           dfactor = fdec_pkg::DECIM_RESET;

  logic signed [fdec_pkg::SAMPLE_BITS-1:0] corner_samples [10] = '{
    16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0001, 16'shffff,
    16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh4000
  };
  logic [fdec_pkg::FACTOR_W-1:0] phase_factor [PHASES] = '{
    7'd1, 7'd64, 7'd0, 7'd127, 7'd3, 7'd1, 7'd2, 7'd7, 7'd64, 7'd33
  };

  initial forever #5 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic fir_req_t make_req(input logic cmd,
                                        input logic [fdec_pkg::SAMPLE_BITS-1:0] s,
                                        input logic [7:0] ti,
                                        input logic [fdec_pkg::COEF_BITS-1:0] tv);
    fir_req_t r;
    r.cmd = cmd;
    r.sample = s;
    r.tidx = ti;
    r.tval = tv;
    return r;
  endfunction

  // Append a request at the tail of the pending queue.
  task automatic enqueue_req(input fir_req_t r);
    req_queue.insert(req_queue.size(), r);
  endtask

  // Queue a full tap table of random taps bounded by a triangle window, spread set by scale.
  task automatic queue_tap_load(input int scale);
    int w;
    for (int k = 0; k < fdec_pkg::TAPS; k++) begin
      w = ((k < fdec_pkg::TAPS - 1 - k) ? k : fdec_pkg::TAPS - 1 - k) + 1;
      enqueue_req(make_req(fdec_pkg::CMD_COEF, 16'($urandom), 8'(k),
                           18'(int'($urandom_range(0, 2 * w * scale)) - w * scale)));
    end
  endtask

  // Advance the shadow state by one accepted request; queue the output it causes.
  function automatic void fir_predict(input fir_req_t r);
    int       eff;
    int       idx;
    longint   acc;
    longint   rounded;
    fir_out_t res;
    if (r.cmd == fdec_pkg::CMD_COEF) begin
      // Drop writes past the end of the table.
      if (r.tidx < fdec_pkg::TAPS) coef_table[r.tidx] = r.tval;
      return;
    end
    hist_ring[wr_ptr] = r.sample;
    wr_ptr = (wr_ptr == fdec_pkg::TAPS - 1) ? 0 : wr_ptr + 1;
    if (held < fdec_pkg::TAPS) held++;
    if (held < fdec_pkg::TAPS) return;
    // Zero acts as one; anything past the maximum is clamped.
    eff = (dfactor == 0) ? 1 :
          (dfactor > fdec_pkg::DECIM_MAX) ? fdec_pkg::DECIM_MAX : int'(dfactor);
    if (dphase >= eff) dphase = 0;
    if (dphase != 0) begin
      dphase++;
      if (dphase >= eff) dphase = 0;
      return;
    end
    dphase = (eff > 1) ? 1 : 0;
    // Oldest sample meets tap 0, newest meets the last tap.
    acc = 0;
    idx = wr_ptr;
    for (int k = 0; k < fdec_pkg::TAPS; k++) begin
      acc += longint'(hist_ring[idx]) * longint'(coef_table[k]);
      idx = (idx == fdec_pkg::TAPS - 1) ? 0 : idx + 1;
    end
    rounded = (acc + (longint'(1) <<< (fdec_pkg::SHIFT - 1))) >>> fdec_pkg::SHIFT;
    res.sat = 1'b0;
    if (rounded > OUT_HI) begin
      rounded = OUT_HI;
      res.sat = 1'b1;
    end else if (rounded < OUT_LO) begin
      rounded = OUT_LO;
      res.sat = 1'b1;
    end
    res.value = fdec_pkg::SAMPLE_BITS'(rounded);
    out_expected.insert(out_expected.size(), res);
  endfunction

  // Wait until every request is out and every output is back, then hold off a pass.
  task automatic settle();
    do begin
      @(posedge clk);
      #1;
    end while (req_queue.size() != 0 || s_axis_tvalid || out_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    #1;
  endtask

  // Note each request the block took at this edge; the driver acts on it.
  always @(posedge clk) begin
    req_fire <= !rst && s_axis_tvalid && s_axis_tready;
  end

  // Driver: change inputs on the falling edge. Predict first, then present the
  // next request or idle. Valid stays up until the request is taken.
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (req_fire) fir_predict(held_req);
      if (!s_axis_tvalid || req_fire) begin
        if (req_queue.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          held_req = req_queue.pop_front();
          // Pack tap value, tap index and sample from the top down, zero pad first.
          s_axis_tdata  <= {6'b0, held_req.tval, held_req.tidx, held_req.sample};
          s_axis_tuser  <= held_req.cmd;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      // Stall the output side at random, except during the calm stretch.
      m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Monitor: compare each output taken at a rising edge with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (out_expected.size() == 0) begin
        flag_mismatch($sformatf("output %0d with none expected", $signed(m_axis_tdata)));
      end else begin
        out_head = out_expected.pop_front();
        if (m_axis_tdata !== out_head.value)
          flag_mismatch($sformatf("sample_out got %0d want %0d",
                                  $signed(m_axis_tdata), out_head.value));
        if (m_axis_tuser !== out_head.sat)
          flag_mismatch($sformatf("saturated got %b want %b", m_axis_tuser, out_head.sat));
      end
    end
  end

  initial begin
    fir_req_t r;
    int       roll;
    logic [fdec_pkg::FACTOR_W-1:0] f;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset factor. Load the whole table before any
    // output can read it, with full-scale taps at both ends so the corner
    // samples clip in either direction.
    queue_tap_load(4);
    enqueue_req(make_req(fdec_pkg::CMD_COEF, 16'h0000, 8'd0, 18'sh1ffff));
    enqueue_req(make_req(fdec_pkg::CMD_COEF, 16'h0000, 8'd254, 18'sh20000));
    // Index past the table: must be dropped.
    enqueue_req(make_req(fdec_pkg::CMD_COEF, 16'hffff, 8'd255, 18'sh1ffff));
    // Fill the ring short of one; the next sample completes the window.
    repeat (fdec_pkg::TAPS - 1)
      enqueue_req(make_req(fdec_pkg::CMD_SAMPLE, 16'($urandom), 8'($urandom),
                           18'($urandom)));
    foreach (corner_samples[i])
      enqueue_req(make_req(fdec_pkg::CMD_SAMPLE, corner_samples[i], 8'hff, 18'h3ffff));
    settle();

    // Random phases, each at its own factor; the decimation phase carries over
    // between them, so a smaller factor after a larger one exercises the wrap.
    for (int p = 0; p < PHASES; p++) begin
      calm = (p == 5);
      f = (p == PHASES - 1) ?
          fdec_pkg::FACTOR_W'($urandom_range(1, fdec_pkg::DECIM_MAX)) : phase_factor[p];

      // Register write: setup cycle, then access until pready.
      @(negedge clk);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {fdec_pkg::REG_DECIM_FACTOR, 2'b00};
      pwdata  <= 32'(f);
      @(negedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      @(negedge clk);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      dfactor = f;

      repeat (ITEMS_PER_PHASE) begin
        roll = $urandom_range(0, 99);
        r = make_req(fdec_pkg::CMD_SAMPLE, 16'($urandom), 8'($urandom), 18'($urandom));
        if (roll < 12) begin
          r.cmd = fdec_pkg::CMD_COEF;
          // Keep taps small except in the last phases, where full-range
          // values are allowed for a third of the writes.
          if (p < PHASES - 2 || $urandom_range(0, 2) != 0)
            r.tval = 18'(int'($urandom_range(0, 1024)) - 512);
        end else if (roll >= 95) begin
          r.sample = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
        end
        enqueue_req(r);
      end
      settle();
    end

    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(12_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- fir_decimator_windowed_sinc.f -----
+incdir+rtl/core
rtl/core/fdec_pkg.sv
rtl/core/fir_decimator_windowed_sinc.sv
tb/tb_top.sv
